// File: sv/assert_macros.svh
// assertion macros used by the rtl file grid_face_neighbor_finder.sv
// no dependencies; pulled in by `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent now implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gfn_pkg.sv
// package for the grid face neighbor finder
// widths, register and direction codes, pipeline payload type; no dependencies
package gfn_pkg;

    localparam int SIZE_W      = 7;
    localparam int PLANE_W     = 2 * SIZE_W;
    localparam int COUNT_W     = 3 * SIZE_W;
    localparam int IDX_W       = 18;
    localparam int IDX_BYTES_W = 24;
    localparam int DIR_W       = 3;
    localparam int NUM_DIR     = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STAGES  = SIZE_W;
    localparam int PIPE_LAST   = 2 * DIV_STAGES;

    localparam int MAX_AXIS_CELLS_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Z = 3'd5;

    localparam int DIR_NEG_X = 0;
    localparam int DIR_POS_X = 1;
    localparam int DIR_NEG_Y = 2;
    localparam int DIR_POS_Y = 3;
    localparam int DIR_NEG_Z = 4;
    localparam int DIR_POS_Z = 5;

    // payload of one divider stage
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  rem;
        logic [SIZE_W-1:0] qz;
        logic [SIZE_W-1:0] qy;
    } pipe_t;

endpackage

// File: sv/grid_face_neighbor_finder.sv
// grid face neighbor finder: cell index in, up to six face neighbor indices out
// uses gfn_pkg and assert_macros.svh
//
// usage
//   s_axis: one transaction per cell index. m_axis: one transaction per face
//   neighbor, in the order -x, +x, -y, +y, -z, +z, tlast on the final one of a
//   cell; a cell outside the grid gives no transaction at all.
//   cfg: register writes (size_x, size_y, size_z, wrap_x, wrap_y, wrap_z), cfg_ready
//   is always high. after a write s_axis_tready stays low while
//   plane and cell counts are recomputed by two multiplier stages.
// pipeline: entry register, 7 z and 7 y long division stages, neighbor stage,
//   emitter.
// throughput: an index with k neighbors holds the emitter until its k neighbors
//   are sent, six for an interior or fully periodic cell; indices with no
//   neighbors pass at one per cycle unless held by the emitter or a register write.
// reset: sizes 1, all axes periodic, pipeline empty.
// stall: when m_axis_tready is low with a neighbor pending, the emitter and every
//   stage behind it hold, and s_axis_tready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module grid_face_neighbor_finder #(
    parameter int MAX_AXIS_CELLS = gfn_pkg::MAX_AXIS_CELLS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gfn_pkg::IDX_BYTES_W-1:0]    s_axis_tdata,  // [17:0] cell_index
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gfn_pkg::IDX_BYTES_W-1:0]    m_axis_tdata,  // [17:0] neighbor_index
    output logic [gfn_pkg::DIR_W-1:0]          m_axis_tuser,  // [2:0] direction_code
    output logic                               m_axis_tlast,  // last_neighbor
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gfn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gfn_pkg::SIZE_W-1:0]         cfg_data
);

    localparam int SW = gfn_pkg::SIZE_W;
    localparam int IW = gfn_pkg::IDX_W;
    localparam int PW = gfn_pkg::PLANE_W;
    localparam int CW = gfn_pkg::COUNT_W;
    localparam int ND = gfn_pkg::NUM_DIR;
    localparam int DS = gfn_pkg::DIV_STAGES;
    localparam int PL = gfn_pkg::PIPE_LAST;

    // configuration registers
    logic [SW-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic          wrap_x_reg, wrap_y_reg, wrap_z_reg;
    logic [1:0]    settle_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SW'(1);
            size_y_reg <= SW'(1);
            size_z_reg <= SW'(1);
            wrap_x_reg <= 1'b1;
            wrap_y_reg <= 1'b1;
            wrap_z_reg <= 1'b1;
            settle_reg <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                settle_reg <= 2'd2;
                unique case (cfg_index)
                    gfn_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                    gfn_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                    gfn_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data;
                    gfn_pkg::CFG_WRAP_X: wrap_x_reg <= cfg_data[0];
                    gfn_pkg::CFG_WRAP_Y: wrap_y_reg <= cfg_data[0];
                    gfn_pkg::CFG_WRAP_Z: wrap_z_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // derived grid constants, two multiplier stages
    logic [SW-1:0] nx_c, ny_c, nz_c;
    logic [SW-1:0] nx_reg, ny_reg, nz_reg;
    logic [PW-1:0] plane_reg;
    logic [CW-1:0] count_reg, pmx_reg, cmp_reg;

    always_comb
    begin
        nx_c = (32'(size_x_reg) > MAX_AXIS_CELLS) ? SW'(MAX_AXIS_CELLS) : size_x_reg;
        ny_c = (32'(size_y_reg) > MAX_AXIS_CELLS) ? SW'(MAX_AXIS_CELLS) : size_y_reg;
        nz_c = (32'(size_z_reg) > MAX_AXIS_CELLS) ? SW'(MAX_AXIS_CELLS) : size_z_reg;
    end

    // reset values match a 1x1x1 grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg    <= SW'(1);
            ny_reg    <= SW'(1);
            nz_reg    <= SW'(1);
            plane_reg <= PW'(1);
            count_reg <= CW'(1);
            cmp_reg   <= '0;
            pmx_reg   <= '0;
        end
        else
        begin
            nx_reg    <= nx_c;
            ny_reg    <= ny_c;
            nz_reg    <= nz_c;
            plane_reg <= PW'(nx_c) * PW'(ny_c);
            count_reg <= CW'(plane_reg) * CW'(nz_reg);
            cmp_reg   <= CW'(plane_reg) * CW'(nz_reg - SW'(1));
            pmx_reg   <= CW'(plane_reg) - CW'(nx_reg);
        end
    end

    // pipeline advance
    logic [ND-1:0] em_mask_reg;
    logic [ND-1:0] em_rest;
    logic          em_last;
    logic          adv;

    assign adv           = (em_mask_reg == '0) || (m_axis_tready && em_last);
    assign s_axis_tready = adv && (settle_reg == 2'd0);

    // entry stage plus long division stages
    logic              vld_reg [0:PL];
    gfn_pkg::pipe_t    pl_reg  [0:PL];
    gfn_pkg::pipe_t    pl_next [1:PL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_axis_tvalid && s_axis_tready
                          && ({{(CW-IW){1'b0}}, s_axis_tdata[IW-1:0]} < count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pl_reg[0].idx <= s_axis_tdata[IW-1:0];
            pl_reg[0].rem <= s_axis_tdata[IW-1:0];
            pl_reg[0].qz  <= '0;
            pl_reg[0].qy  <= '0;
        end
    end

    for (genvar k = 1; k <= PL; k++)
    begin : g_div
        localparam int BIT = (k <= DS) ? (DS - k) : (PL - k);
        logic [CW-1:0] dv;
        logic [CW-1:0] rem_w;
        logic [CW-1:0] diff;

        always_comb
        begin
            if (k <= DS)
            begin
                dv = CW'(plane_reg) << BIT;
            end
            else
            begin
                dv = CW'(nx_reg) << BIT;
            end
            rem_w      = CW'(pl_reg[k-1].rem);
            diff       = rem_w - dv;
            pl_next[k] = pl_reg[k-1];
            if (rem_w >= dv)
            begin
                pl_next[k].rem = diff[IW-1:0];
                if (k <= DS)
                begin
                    pl_next[k].qz[BIT] = 1'b1;
                end
                else
                begin
                    pl_next[k].qy[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pl_reg[k] <= pl_next[k];
            end
        end
    end

    // neighbor stage
    logic [SW-1:0] ci, cj, ck;
    logic [IW-1:0] idx;
    logic [IW-1:0] nxm1_i, nx_i, plane_i, pmx_i, cmp_i;
    logic          lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic [ND-1:0] nb_mask;
    logic [IW-1:0] nb_idx [0:ND-1];

    logic          nb_vld_reg;
    logic [ND-1:0] nb_mask_reg;
    logic [IW-1:0] nb_idx_reg [0:ND-1];

    always_comb
    begin
        ci      = pl_reg[PL].rem[SW-1:0];
        cj      = pl_reg[PL].qy;
        ck      = pl_reg[PL].qz;
        idx     = pl_reg[PL].idx;
        nxm1_i  = IW'(nx_reg - SW'(1));
        nx_i    = IW'(nx_reg);
        plane_i = IW'(plane_reg);
        pmx_i   = pmx_reg[IW-1:0];
        cmp_i   = cmp_reg[IW-1:0];
        lo_x    = (ci == '0);
        hi_x    = (ci == nx_reg - SW'(1));
        lo_y    = (cj == '0);
        hi_y    = (cj == ny_reg - SW'(1));
        lo_z    = (ck == '0);
        hi_z    = (ck == nz_reg - SW'(1));

        nb_mask[gfn_pkg::DIR_NEG_X] = wrap_x_reg || !lo_x;
        nb_mask[gfn_pkg::DIR_POS_X] = wrap_x_reg || !hi_x;
        nb_mask[gfn_pkg::DIR_NEG_Y] = wrap_y_reg || !lo_y;
        nb_mask[gfn_pkg::DIR_POS_Y] = wrap_y_reg || !hi_y;
        nb_mask[gfn_pkg::DIR_NEG_Z] = wrap_z_reg || !lo_z;
        nb_mask[gfn_pkg::DIR_POS_Z] = wrap_z_reg || !hi_z;

        nb_idx[gfn_pkg::DIR_NEG_X] = lo_x ? idx + nxm1_i  : idx - IW'(1);
        nb_idx[gfn_pkg::DIR_POS_X] = hi_x ? idx - nxm1_i  : idx + IW'(1);
        nb_idx[gfn_pkg::DIR_NEG_Y] = lo_y ? idx + pmx_i   : idx - nx_i;
        nb_idx[gfn_pkg::DIR_POS_Y] = hi_y ? idx - pmx_i   : idx + nx_i;
        nb_idx[gfn_pkg::DIR_NEG_Z] = lo_z ? idx + cmp_i   : idx - plane_i;
        nb_idx[gfn_pkg::DIR_POS_Z] = hi_z ? idx - cmp_i   : idx + plane_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            nb_vld_reg <= vld_reg[PL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nb_mask_reg <= nb_mask;
            nb_idx_reg  <= nb_idx;
        end
    end

    // emitter: one neighbor per transaction, lowest direction first
    logic [IW-1:0]             em_idx_reg [0:ND-1];
    logic [gfn_pkg::DIR_W-1:0] em_sel;
    logic                      out_fire;

    always_comb
    begin
        em_sel = '0;
        for (int d = ND - 1; d >= 0; d--)
        begin
            if (em_mask_reg[d])
            begin
                em_sel = gfn_pkg::DIR_W'(d);
            end
        end
        em_rest = em_mask_reg & ~(ND'(1) << em_sel);
        em_last = (em_rest == '0);
    end

    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_mask_reg <= '0;
        end
        else if (adv)
        begin
            em_mask_reg <= nb_vld_reg ? nb_mask_reg : '0;
        end
        else if (out_fire)
        begin
            em_mask_reg <= em_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            em_idx_reg <= nb_idx_reg;
        end
    end

    assign m_axis_tvalid = (em_mask_reg != '0);
    assign m_axis_tdata  = {{(gfn_pkg::IDX_BYTES_W - IW){1'b0}}, em_idx_reg[em_sel]};
    assign m_axis_tuser  = em_sel;
    assign m_axis_tlast  = em_last;

    // checks
    `ASSERT_NEXT(a_cfg_blocks_intake, clk, rst_n, cfg_valid && cfg_ready, !s_axis_tready, "intake open right after a register write")
    `ASSERT_CLK(a_stall_blocks_intake, clk, rst_n, !(m_axis_tvalid && !m_axis_tready && s_axis_tready), "intake open while output stalled")
    `ASSERT_NEXT(a_more_follow, clk, rst_n, out_fire && !m_axis_tlast, m_axis_tvalid, "neighbor run ended without tlast")
    `ASSERT_NEXT(a_dir_order, clk, rst_n, out_fire && !m_axis_tlast, m_axis_tuser > $past(m_axis_tuser), "directions out of order")

endmodule
